// ----- hw/rtl/stun_binding_response_parser_macros.svh -----
// ----------------------------------------------------------------------------
// STUN binding response parser assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef STUN_BINDING_RESPONSE_PARSER_MACROS_SVH
`define STUN_BINDING_RESPONSE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SBRP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SBRP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define SBRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/stun_bp_pkg.sv -----
// ----------------------------------------------------------------------------
// STUN binding response parser package
// Protocol constants, status codes and the result record.
// ----------------------------------------------------------------------------
package stun_bp_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 512;
  localparam int HEADER_BYTES         = 20;

  localparam logic [15:0] TYPE_BINDING_RESPONSE = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED           = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED       = 16'h0020;
  localparam logic [15:0] FAMILY_IPV4           = 16'h0001;
  localparam logic [31:0] MAGIC_COOKIE          = 32'h2112_A442;

  localparam logic [2:0] ST_NOT_BINDING = 3'd0;
  localparam logic [2:0] ST_FOUND       = 3'd1;
  localparam logic [2:0] ST_TOO_LONG    = 3'd2;
  localparam logic [2:0] ST_OVERRUN     = 3'd3;
  localparam logic [2:0] ST_BAD_LEN     = 3'd4;
  localparam logic [2:0] ST_NOT_IPV4    = 3'd5;
  localparam logic [2:0] ST_NONE        = 3'd6;
  localparam logic [2:0] ST_HALTED      = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ext_address;
    logic [15:0] ext_port;
    logic        have_address;
  } result_t;

endpackage

// ----- hw/rtl/stun_bp_in_if.sv -----
// ----------------------------------------------------------------------------
// STUN parser byte channel
// valid/ready channel carrying one datagram byte and its last flag.
// ----------------------------------------------------------------------------
interface stun_bp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/stun_bp_out_if.sv -----
// ----------------------------------------------------------------------------
// STUN parser result channel
// valid/ready channel carrying one per-datagram verdict.
// ----------------------------------------------------------------------------
interface stun_bp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] ext_address;
  logic [15:0] ext_port;
  logic        have_address;

  modport source (output valid, output status, output ext_address, output ext_port,
                  output have_address, input ready);
  modport sink   (input valid, input status, input ext_address, input ext_port,
                  input have_address, output ready);
endinterface

// ----- hw/rtl/stun_bp_core.sv -----
// ----------------------------------------------------------------------------
// STUN parser core
// Per-byte parse state and its next-state logic; forms the verdict on last.
// ----------------------------------------------------------------------------
`include "stun_binding_response_parser_macros.svh"

module stun_bp_core #(
  parameter int BUFFER_BYTES = stun_bp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                last_byte,
  output stun_bp_pkg::result_t result
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int W     = 18;  // holds offset + 1 + 16-bit length
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(BUFFER_BYTES);
  localparam logic [15:0]      BODY_MAX = 16'(BUFFER_BYTES - stun_bp_pkg::HEADER_BYTES);
  localparam logic [W-1:0]     HDR_W    = W'(stun_bp_pkg::HEADER_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next, pos_inc;
  logic [15:0] message_type, message_type_next;
  logic [15:0] body_length, body_length_next;
  logic [15:0] attr_position, attr_position_next;
  logic [15:0] attr_kind, attr_kind_next;
  logic [15:0] attr_length, attr_length_next;
  logic [31:0] family_and_port, family_and_port_next;
  logic [31:0] address_shift, address_shift_next;
  logic [2:0]  pending_verdict, pending_verdict_next;
  logic        verdict_valid, verdict_valid_next;
  logic        halted_on_error, halted_on_error_next;
  logic        address_captured, address_captured_next;
  logic [31:0] saved_address, saved_address_next;
  logic [15:0] saved_port, saved_port_next;

  logic        take;
  logic        mapped;
  logic        hold_pos;
  logic [W-1:0] pos_w, off_w, body_w;
  logic [15:0] word_new, attr_v;
  logic [31:0] shift_new;
  logic [16:0] attr_inc;
  logic [2:0]  st;
  logic [31:0] addr_x;
  logic [15:0] port_x;

  assign mapped = (attr_kind == stun_bp_pkg::ATTR_MAPPED) ||
                  (attr_kind == stun_bp_pkg::ATTR_XOR_MAPPED);
  assign pos_w  = W'(byte_position);
  assign off_w  = pos_w - HDR_W;
  assign body_w = W'(body_length);
  assign attr_v = attr_position - 16'd4;
  assign take   = step && !halted_on_error && !address_captured && !verdict_valid &&
                  (byte_position < POS_MAX);
  assign pos_inc = (byte_position < POS_MAX) ? byte_position + POS_W'(1) : byte_position;

  always_comb begin
    byte_position_next    = byte_position;
    message_type_next     = message_type;
    body_length_next      = body_length;
    attr_position_next    = attr_position;
    attr_kind_next        = attr_kind;
    attr_length_next      = attr_length;
    family_and_port_next  = family_and_port;
    address_shift_next    = address_shift;
    pending_verdict_next  = pending_verdict;
    verdict_valid_next    = verdict_valid;
    halted_on_error_next  = halted_on_error;
    address_captured_next = address_captured;
    saved_address_next    = saved_address;
    saved_port_next       = saved_port;
    word_new  = 16'h0;
    shift_new = 32'h0;
    attr_inc  = 17'h0;
    hold_pos  = 1'b0;
    st        = stun_bp_pkg::ST_NONE;
    addr_x    = 32'h0;
    port_x    = 16'h0;

    if (step) begin
      byte_position_next = pos_inc;
    end

    if (take) begin
      if (pos_w < W'(2)) begin
        word_new = {message_type[7:0], rx_byte};
        message_type_next = word_new;
        if (pos_w == W'(1) && word_new != stun_bp_pkg::TYPE_BINDING_RESPONSE) begin
          pending_verdict_next = stun_bp_pkg::ST_NOT_BINDING;
          verdict_valid_next   = 1'b1;
        end
      end else if (pos_w < W'(4)) begin
        word_new = {body_length[7:0], rx_byte};
        body_length_next = word_new;
        if (pos_w == W'(3) && word_new > BODY_MAX) begin
          pending_verdict_next = stun_bp_pkg::ST_TOO_LONG;
          verdict_valid_next   = 1'b1;
        end
      end else if (pos_w >= HDR_W && off_w < body_w) begin
        case (attr_position)
          16'd0: begin
            if (body_w < off_w + W'(4)) begin
              pending_verdict_next = stun_bp_pkg::ST_OVERRUN;
              verdict_valid_next   = 1'b1;
            end else begin
              attr_kind_next     = {8'h00, rx_byte};
              attr_position_next = 16'd1;
            end
          end
          16'd1: begin
            attr_kind_next     = {attr_kind[7:0], rx_byte};
            attr_position_next = 16'd2;
          end
          16'd2: begin
            attr_length_next   = {8'h00, rx_byte};
            attr_position_next = 16'd3;
          end
          16'd3: begin
            word_new = {attr_length[7:0], rx_byte};
            attr_length_next = word_new;
            if (off_w + W'(1) + W'(word_new) > body_w) begin
              pending_verdict_next = stun_bp_pkg::ST_OVERRUN;
              verdict_valid_next   = 1'b1;
            end else if (mapped && word_new != 16'd8) begin
              pending_verdict_next = stun_bp_pkg::ST_BAD_LEN;
              verdict_valid_next   = 1'b1;
            end else begin
              attr_position_next = (word_new == 16'd0) ? 16'd0 : 16'd4;
            end
          end
          default: begin
            if (mapped) begin
              if (attr_v < 16'd4) begin
                shift_new = {family_and_port[23:0], rx_byte};
                family_and_port_next = shift_new;
                if (attr_v == 16'd1 && shift_new[15:0] != stun_bp_pkg::FAMILY_IPV4) begin
                  pending_verdict_next = stun_bp_pkg::ST_NOT_IPV4;
                  verdict_valid_next   = 1'b1;
                  hold_pos             = 1'b1;
                end
              end else begin
                shift_new = {address_shift[23:0], rx_byte};
                address_shift_next = shift_new;
                if (attr_v == 16'd7) begin
                  pending_verdict_next = stun_bp_pkg::ST_FOUND;
                  verdict_valid_next   = 1'b1;
                  hold_pos             = 1'b1;
                end
              end
            end
            if (!hold_pos) begin
              attr_inc = 17'(attr_position) + 17'd1;
              attr_position_next = (attr_inc >= 17'(attr_length) + 17'd4) ?
                                   16'd0 : attr_inc[15:0];
            end
          end
        endcase
      end
    end

    if (step && last_byte) begin
      if (halted_on_error) begin
        st = stun_bp_pkg::ST_HALTED;
      end else if (address_captured) begin
        st = stun_bp_pkg::ST_FOUND;
      end else begin
        if (verdict_valid_next) begin
          st = pending_verdict_next;
        end else if (W'(pos_inc) < HDR_W) begin
          st = stun_bp_pkg::ST_NOT_BINDING;
        end else if (W'(pos_inc) < HDR_W + W'(body_length_next)) begin
          st = stun_bp_pkg::ST_OVERRUN;
        end else begin
          st = stun_bp_pkg::ST_NONE;
        end
        if (st == stun_bp_pkg::ST_FOUND) begin
          addr_x = address_shift_next;
          port_x = family_and_port_next[15:0];
          if (attr_kind_next == stun_bp_pkg::ATTR_XOR_MAPPED) begin
            addr_x = addr_x ^ stun_bp_pkg::MAGIC_COOKIE;
            port_x = port_x ^ stun_bp_pkg::MAGIC_COOKIE[31:16];
          end
          saved_address_next    = addr_x;
          saved_port_next       = port_x;
          address_captured_next = 1'b1;
        end else if (st inside {[stun_bp_pkg::ST_TOO_LONG:stun_bp_pkg::ST_NOT_IPV4]}) begin
          halted_on_error_next = 1'b1;
        end
      end
      // datagram done: drop all per-datagram state
      byte_position_next   = '0;
      message_type_next    = 16'h0;
      body_length_next     = 16'h0;
      attr_position_next   = 16'h0;
      attr_kind_next       = 16'h0;
      attr_length_next     = 16'h0;
      family_and_port_next = 32'h0;
      address_shift_next   = 32'h0;
      pending_verdict_next = 3'd0;
      verdict_valid_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      message_type     <= 16'h0;
      body_length      <= 16'h0;
      attr_position    <= 16'h0;
      attr_kind        <= 16'h0;
      attr_length      <= 16'h0;
      family_and_port  <= 32'h0;
      address_shift    <= 32'h0;
      pending_verdict  <= 3'd0;
      verdict_valid    <= 1'b0;
      halted_on_error  <= 1'b0;
      address_captured <= 1'b0;
      saved_address    <= 32'h0;
      saved_port       <= 16'h0;
    end else begin
      byte_position    <= byte_position_next;
      message_type     <= message_type_next;
      body_length      <= body_length_next;
      attr_position    <= attr_position_next;
      attr_kind        <= attr_kind_next;
      attr_length      <= attr_length_next;
      family_and_port  <= family_and_port_next;
      address_shift    <= address_shift_next;
      pending_verdict  <= pending_verdict_next;
      verdict_valid    <= verdict_valid_next;
      halted_on_error  <= halted_on_error_next;
      address_captured <= address_captured_next;
      saved_address    <= saved_address_next;
      saved_port       <= saved_port_next;
    end
  end

  assign result.status       = st;
  assign result.ext_address  = saved_address_next;
  assign result.ext_port     = saved_port_next;
  assign result.have_address = address_captured_next;

  `SBRP_ASSERT_IMPLIES(a_sticky_exclusive, clk, rst, halted_on_error, !address_captured, "halted and captured both set")
  `SBRP_ASSERT_NEXT(a_capture_sticky, clk, rst, address_captured, address_captured, "captured address lost")
  `SBRP_ASSERT_IMPLIES(a_pos_bound, clk, rst, 1'b1, byte_position <= POS_MAX, "byte position past buffer")
  `SBRP_ASSERT_NEXT(a_clear_on_last, clk, rst, step && last_byte, byte_position == '0 && !verdict_valid, "datagram state not cleared")

endmodule

// ----- hw/rtl/stun_binding_response_parser.sv -----
// ----------------------------------------------------------------------------
// STUN binding response parser
// Parses a datagram byte stream and reports the mapped IPv4 address.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          request per
//  rx       in   rx_byte, last_byte                               byte
//  res      out  status, ext_address, ext_port, have_address      datagram
//
// One byte per cycle while rx is not stalled: input register, single-pass core logic, output register.
// An accepted byte is held in the input register for the core; the verdict is
// captured into the output register for res when the last byte advances.
// rx stalls only when a last byte waits behind an untaken result.
// Synchronous active-high reset clears all parse state and the sticky flags;
// rx is not ready while reset is held.
module stun_binding_response_parser #(
  parameter int BUFFER_BYTES = stun_bp_pkg::BUFFER_BYTES_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  stun_bp_in_if.sink   rx,
  stun_bp_out_if.source res
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       out_vld;
  stun_bp_pkg::result_t out_data;
  stun_bp_pkg::result_t core_result;

  // a non-last byte never needs the output register
  assign advance  = in_vld && (!in_last || !out_vld || res.ready);
  assign rx.ready = !rst && (!in_vld || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (rx.ready) begin
      in_vld <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
      in_last <= rx.last_byte;
    end
  end

  stun_bp_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .last_byte(in_last),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_last) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_data <= core_result;
    end
  end

  assign res.valid        = out_vld;
  assign res.status       = out_data.status;
  assign res.ext_address  = out_data.ext_address;
  assign res.ext_port     = out_data.ext_port;
  assign res.have_address = out_data.have_address;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN binding response parser testbench
// Streams datagrams through the parser one byte per request, with random
// idling on both channels, and checks every per-datagram verdict against a
// pinned expectation or a behavioral predictor of the parse in this module.
// ----------------------------------------------------------------------------
module tb;

  localparam int BUF_BYTES   = stun_bp_pkg::BUFFER_BYTES_DEFAULT;
  localparam int HDR_BYTES   = stun_bp_pkg::HEADER_BYTES;
  localparam int MAX_BODY    = BUF_BYTES - HDR_BYTES;
  localparam int QUIET_LIMIT = 1000;
  localparam int GAP_PCT     = 16;

  localparam logic [15:0] T_BIND  = stun_bp_pkg::TYPE_BINDING_RESPONSE;
  localparam logic [15:0] A_MAP   = stun_bp_pkg::ATTR_MAPPED;
  localparam logic [15:0] A_XOR   = stun_bp_pkg::ATTR_XOR_MAPPED;
  localparam logic [15:0] FAM_V4  = stun_bp_pkg::FAMILY_IPV4;
  localparam logic [31:0] COOKIE  = stun_bp_pkg::MAGIC_COOKIE;

  typedef enum {
    DG_NOISE, DG_SHORT, DG_CLEAN, DG_BIG,
    DG_MAPPED, DG_XOR, DG_TOO_LONG, DG_TRUNC, DG_ATTR_OVER, DG_BAD_LEN, DG_NOT_IPV4
  } dg_kind_t;

  typedef struct {
    dg_kind_t   kind;
    int         n;
    logic       on;
    logic [2:0] status;
  } row_t;

  typedef struct {
    logic                 on;
    stun_bp_pkg::result_t want;
  } pin_t;

  logic clk = 1'b0;
  logic rst;

  stun_bp_in_if  rx_ch ();
  stun_bp_out_if res_ch ();

  stun_binding_response_parser #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  int          pos;
  int          a_pos;
  logic [15:0] m_type, b_len, a_kind, a_len;
  logic [31:0] fam_port, addr_sh, saved_addr;
  logic [15:0] saved_port;
  logic [2:0]  verdict;
  logic        decided, halted, captured;

  stun_bp_pkg::result_t verdict_q[$];
  pin_t        pinned_q[$];
  logic [7:0]  dg[$];
  logic [7:0]  body[$];
  row_t        plan[10];
  int          fails = 0;
  int          sent = 0;
  int          quiet = 0;
  logic        calm;

  // ---------------------------------------------------------------- predictor
  task automatic reopen();
    pos = 0; m_type = '0; b_len = '0; a_pos = 0; a_kind = '0; a_len = '0;
    fam_port = '0; addr_sh = '0; verdict = stun_bp_pkg::ST_NOT_BINDING; decided = 1'b0;
  endtask

  task automatic settle(input logic [2:0] st);
    verdict = st;
    decided = 1'b1;
  endtask

  function automatic logic is_addr_attr();
    return a_kind == A_MAP || a_kind == A_XOR;
  endfunction

  task automatic absorb(input logic [7:0] b, input int p);
    int o;
    int v;
    if (p < 2) begin
      m_type = {m_type[7:0], b};
      if (p == 1 && m_type != T_BIND) settle(stun_bp_pkg::ST_NOT_BINDING);
      return;
    end
    if (p < 4) begin
      b_len = {b_len[7:0], b};
      if (p == 3 && b_len > MAX_BODY) settle(stun_bp_pkg::ST_TOO_LONG);
      return;
    end
    if (p < HDR_BYTES) return;
    o = p - HDR_BYTES;
    if (o >= b_len) return;
    case (a_pos)
      0: begin
        if (b_len - o < 4) begin
          settle(stun_bp_pkg::ST_OVERRUN);
        end else begin
          a_kind = {8'h00, b};
          a_pos = 1;
        end
      end
      1: begin
        a_kind = {a_kind[7:0], b};
        a_pos = 2;
      end
      2: begin
        a_len = {8'h00, b};
        a_pos = 3;
      end
      3: begin
        a_len = {a_len[7:0], b};
        if (o + 1 + a_len > b_len) settle(stun_bp_pkg::ST_OVERRUN);
        else if (is_addr_attr() && a_len != 8) settle(stun_bp_pkg::ST_BAD_LEN);
        else a_pos = (a_len == 0) ? 0 : 4;
      end
      default: begin
        v = a_pos - 4;
        if (is_addr_attr()) begin
          if (v < 4) begin
            fam_port = {fam_port[23:0], b};
            if (v == 1 && fam_port[15:0] != FAM_V4) begin
              settle(stun_bp_pkg::ST_NOT_IPV4);
              return;
            end
          end else begin
            addr_sh = {addr_sh[23:0], b};
            if (v == 7) begin
              settle(stun_bp_pkg::ST_FOUND);
              return;
            end
          end
        end
        a_pos++;
        if (a_pos >= 4 + a_len) a_pos = 0;
      end
    endcase
  endtask

  task automatic track_byte(input logic [7:0] b, input logic fin, output logic emit,
                            output stun_bp_pkg::result_t r);
    logic [2:0]  st;
    logic [31:0] ad;
    logic [15:0] pt;
    emit = 1'b0;
    r = '0;
    if (!halted && !captured && !decided && pos < BUF_BYTES) absorb(b, pos);
    if (pos < BUF_BYTES) pos++;
    if (!fin) return;
    if (halted) begin
      st = stun_bp_pkg::ST_HALTED;
    end else if (captured) begin
      st = stun_bp_pkg::ST_FOUND;
    end else begin
      if (decided) st = verdict;
      else if (pos < HDR_BYTES) st = stun_bp_pkg::ST_NOT_BINDING;
      else if (pos < HDR_BYTES + b_len) st = stun_bp_pkg::ST_OVERRUN;
      else st = stun_bp_pkg::ST_NONE;
      if (st == stun_bp_pkg::ST_FOUND) begin
        ad = addr_sh;
        pt = fam_port[15:0];
        if (a_kind == A_XOR) begin
          ad = ad ^ COOKIE;
          pt = pt ^ COOKIE[31:16];
        end
        saved_addr = ad;
        saved_port = pt;
        captured = 1'b1;
      end else if (st >= stun_bp_pkg::ST_TOO_LONG && st <= stun_bp_pkg::ST_NOT_IPV4) begin
        halted = 1'b1;
      end
    end
    r.status       = st;
    r.ext_address  = saved_addr;
    r.ext_port     = saved_port;
    r.have_address = captured;
    emit = 1'b1;
    reopen();
  endtask

  // ------------------------------------------------------- datagram builders
  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] plain_kind();
    logic [15:0] k;
    do k = 16'($urandom_range(16'hFFFF));
    while (k == A_MAP || k == A_XOR);
    return k;
  endfunction

  function automatic logic [15:0] addr_kind();
    return $urandom_range(1) ? A_MAP : A_XOR;
  endfunction

  function automatic int attr_len();
    return ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(9, 40);
  endfunction

  task automatic body16(input logic [15:0] v);
    body.push_back(v[15:8]);
    body.push_back(v[7:0]);
  endtask

  task automatic add_attr(input logic [15:0] kind, input int len);
    body16(kind);
    body16(16'(len));
    repeat (len) body.push_back(rnd8());
  endtask

  task automatic add_addr(input logic [15:0] kind, input logic [15:0] fam);
    body16(kind);
    body16(16'd8);
    body16(fam);
    repeat (6) body.push_back(rnd8());
  endtask

  // header with random cookie and transaction id, then the body built so far
  task automatic frame(input logic [15:0] typ, input logic [15:0] blen);
    dg.delete();
    dg.push_back(typ[15:8]);
    dg.push_back(typ[7:0]);
    dg.push_back(blen[15:8]);
    dg.push_back(blen[7:0]);
    repeat (16) dg.push_back(rnd8());
    foreach (body[i]) dg.push_back(body[i]);
  endtask

  task automatic build(input dg_kind_t kind, input int n);
    int          cut;
    int          len;
    logic [15:0] fam;
    body.delete();
    case (kind)
      DG_NOISE: begin
        dg.delete();
        repeat (n) dg.push_back(rnd8());
        if (n >= 2 && {dg[0], dg[1]} == T_BIND) dg[1] = ~dg[1];
      end
      DG_SHORT: begin
        frame(T_BIND, 16'($urandom_range(MAX_BODY)));
        while (dg.size() > n) void'(dg.pop_back());
      end
      DG_CLEAN: begin
        repeat (n) add_attr(plain_kind(), attr_len());
        frame(T_BIND, 16'(body.size()));
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 6)) dg.push_back(rnd8());
      end
      DG_BIG: begin
        add_attr(plain_kind(), MAX_BODY - 4);
        frame(T_BIND, 16'(body.size()));
        repeat (n) dg.push_back(rnd8());
      end
      DG_MAPPED, DG_XOR: begin
        repeat (n) add_attr(plain_kind(), attr_len());
        add_addr((kind == DG_XOR) ? A_XOR : A_MAP, FAM_V4);
        if ($urandom_range(1)) add_addr(addr_kind(), FAM_V4);
        frame(T_BIND, 16'(body.size()));
      end
      DG_TOO_LONG: begin
        frame(T_BIND, 16'($urandom_range(MAX_BODY + 1, 16'hFFFF)));
        repeat (n) dg.push_back(rnd8());
      end
      DG_TRUNC: begin
        repeat (n + 1) add_attr(plain_kind(), $urandom_range(1, 12));
        frame(T_BIND, 16'(body.size()));
        cut = $urandom_range(1, body.size());
        repeat (cut) void'(dg.pop_back());
      end
      DG_ATTR_OVER: begin
        repeat (n) add_attr(plain_kind(), attr_len());
        if ($urandom_range(1)) begin
          // declared value runs past the end of the body
          len = $urandom_range(1, 20);
          body16($urandom_range(1) ? addr_kind() : plain_kind());
          body16(16'(len));
          repeat ($urandom_range(len - 1)) body.push_back(rnd8());
        end else begin
          // too few bytes left for an attribute header
          repeat ($urandom_range(1, 3)) body.push_back(rnd8());
        end
        frame(T_BIND, 16'(body.size()));
      end
      DG_BAD_LEN: begin
        repeat (n) add_attr(plain_kind(), attr_len());
        do len = $urandom_range(20);
        while (len == 8);
        add_attr(addr_kind(), len);
        frame(T_BIND, 16'(body.size()));
      end
      default: begin
        repeat (n) add_attr(plain_kind(), attr_len());
        do fam = $urandom_range(1) ? 16'h0002 : 16'($urandom_range(16'hFFFF));
        while (fam == FAM_V4);
        add_addr(addr_kind(), fam);
        frame(T_BIND, 16'(body.size()));
      end
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic push_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < GAP_PCT) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.rx_byte   <= b;
    rx_ch.last_byte <= fin;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_datagram(input dg_kind_t kind, input int n, input logic on,
                               input logic [2:0] st);
    pin_t pin;
    build(kind, n);
    pin.on   = on;
    pin.want = '{status: st, ext_address: 32'h0, ext_port: 16'h0, have_address: 1'b0};
    pinned_q.push_back(pin);
    foreach (dg[i]) push_byte(dg[i], i == dg.size() - 1);
    sent += dg.size();
  endtask

  always @(posedge clk) res_ch.ready <= calm || ($urandom_range(99) >= GAP_PCT);

  // ---------------------------------------------------------------- checking
  function automatic void match_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    logic                 emit;
    stun_bp_pkg::result_t want;
    pin_t                 pin;
    if (!rst) begin
      if (rx_ch.valid && rx_ch.ready) begin
        track_byte(rx_ch.rx_byte, rx_ch.last_byte, emit, want);
        if (emit) begin
          pin = pinned_q.pop_front();
          verdict_q.push_back(pin.on ? pin.want : want);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict request with no datagram outstanding");
          fails++;
        end else begin
          want = verdict_q.pop_front();
          match_field("status", want.status, res_ch.status);
          match_field("ext_address", want.ext_address, res_ch.ext_address);
          match_field("ext_port", want.ext_port, res_ch.ext_port);
          match_field("have_address", want.have_address, res_ch.have_address);
        end
      end
    end
  end

  // no request on either channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL stun_binding_response_parser");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int idx;
    int pick;
    rst             <= 1'b1;
    rx_ch.valid     <= 1'b0;
    rx_ch.rx_byte   <= 8'h00;
    rx_ch.last_byte <= 1'b0;
    calm = 1'b0;
    halted = 1'b0;
    captured = 1'b0;
    saved_addr = '0;
    saved_port = '0;
    reopen();
    plan = '{
      '{DG_NOISE,  1, 1'b1, stun_bp_pkg::ST_NOT_BINDING},  // lone byte
      '{DG_NOISE,  2, 1'b1, stun_bp_pkg::ST_NOT_BINDING},  // wrong type only
      '{DG_SHORT,  3, 1'b1, stun_bp_pkg::ST_NOT_BINDING},  // length field cut short
      '{DG_SHORT, 19, 1'b1, stun_bp_pkg::ST_NOT_BINDING},  // header one byte short
      '{DG_CLEAN,  0, 1'b1, stun_bp_pkg::ST_NONE},         // empty body
      '{DG_NOISE, 36, 1'b1, stun_bp_pkg::ST_NOT_BINDING},  // wrong type, tail ignored
      '{DG_CLEAN,  4, 1'b1, stun_bp_pkg::ST_NONE},
      '{DG_BIG,   24, 1'b1, stun_bp_pkg::ST_NONE},  // largest body, bytes past the buffer
      '{DG_CLEAN,  2, 1'b0, stun_bp_pkg::ST_NONE},
      '{DG_SHORT, 12, 1'b0, stun_bp_pkg::ST_NOT_BINDING}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_datagram(plan[i].kind, plan[i].n, plan[i].on, plan[i].status);

    // mostly well-formed responses without an address; errors and captures are
    // sticky, so exactly one of them closes the random part
    idx = 0;
    while (sent < 1150) begin
      calm = (idx >= 12 && idx < 24);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_datagram(DG_BIG, $urandom_range(8), 1'b0, stun_bp_pkg::ST_NONE);
      end else if (pick < 15) begin
        send_datagram(DG_SHORT, $urandom_range(1, 19), 1'b0, stun_bp_pkg::ST_NONE);
      end else if (pick < 30) begin
        send_datagram(DG_NOISE, $urandom_range(1, 30), 1'b0, stun_bp_pkg::ST_NONE);
      end else begin
        send_datagram(DG_CLEAN, $urandom_range(4), 1'b0, stun_bp_pkg::ST_NONE);
      end
      idx++;
    end
    calm = 1'b0;
    send_datagram(dg_kind_t'(DG_MAPPED + $urandom_range(6)), $urandom_range(3), 1'b0,
                  stun_bp_pkg::ST_NONE);
    while (sent < 1450)
      send_datagram(dg_kind_t'($urandom_range(DG_NOT_IPV4)), $urandom_range(1, 8), 1'b0,
                    stun_bp_pkg::ST_NONE);
    rx_ch.valid <= 1'b0;

    do @(posedge clk);
    while (verdict_q.size() != 0);
    repeat (8) @(posedge clk);
    if (fails == 0) $display("PASS stun_binding_response_parser");
    else $display("FAIL stun_binding_response_parser");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/stun_bp_pkg.sv
hw/rtl/stun_bp_in_if.sv
hw/rtl/stun_bp_out_if.sv
hw/rtl/stun_bp_core.sv
hw/rtl/stun_binding_response_parser.sv
tb/tb.sv
